@@ rtl/kil_pkg.sv @@
// Shared types, token codes and keyword matcher for the keyword/integer lexer.
package kil_pkg;

    localparam int OUT_VALUE_W = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    // Token kinds
    localparam logic [3:0] KIND_RETURN = 4'd0;
    localparam logic [3:0] KIND_IF     = 4'd1;
    localparam logic [3:0] KIND_ELSE   = 4'd2;
    localparam logic [3:0] KIND_ELIF   = 4'd3;
    localparam logic [3:0] KIND_INT    = 4'd4;
    localparam logic [3:0] KIND_SEMI   = 4'd5;
    localparam logic [3:0] KIND_COMMA  = 4'd6;
    localparam logic [3:0] KIND_DOT    = 4'd7;
    localparam logic [3:0] KIND_LPAREN = 4'd8;
    localparam logic [3:0] KIND_RPAREN = 4'd9;

    // Keyword prefix states
    localparam logic [3:0] KW_START  = 4'd0;
    localparam logic [3:0] KW_R      = 4'd1;
    localparam logic [3:0] KW_RE     = 4'd2;
    localparam logic [3:0] KW_RET    = 4'd3;
    localparam logic [3:0] KW_RETU   = 4'd4;
    localparam logic [3:0] KW_RETUR  = 4'd5;
    localparam logic [3:0] KW_RETURN = 4'd6;
    localparam logic [3:0] KW_I      = 4'd7;
    localparam logic [3:0] KW_IF     = 4'd8;
    localparam logic [3:0] KW_E      = 4'd9;
    localparam logic [3:0] KW_EL     = 4'd10;
    localparam logic [3:0] KW_ELS    = 4'd11;
    localparam logic [3:0] KW_ELSE   = 4'd12;
    localparam logic [3:0] KW_ELI    = 4'd13;
    localparam logic [3:0] KW_ELIF   = 4'd14;
    localparam logic [3:0] KW_DEAD   = 4'd15;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WORD = 3'b010,
        MODE_NUM  = 3'b100
    } t_mode;

    typedef struct packed {
        logic [3:0]             kind;
        logic [OUT_VALUE_W-1:0] value;
        logic                   ovf;
        logic                   last;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_slot;

    function automatic logic [3:0] kw_next(input logic [3:0] s, input logic [7:0] c);
        logic [3:0] nxt;
        nxt = KW_DEAD;
        case (s)
            KW_START: begin
                if (c == "r")      nxt = KW_R;
                else if (c == "i") nxt = KW_I;
                else if (c == "e") nxt = KW_E;
            end
            KW_R:     if (c == "e") nxt = KW_RE;
            KW_RE:    if (c == "t") nxt = KW_RET;
            KW_RET:   if (c == "u") nxt = KW_RETU;
            KW_RETU:  if (c == "r") nxt = KW_RETUR;
            KW_RETUR: if (c == "n") nxt = KW_RETURN;
            KW_I:     if (c == "f") nxt = KW_IF;
            KW_E:     if (c == "l") nxt = KW_EL;
            KW_EL: begin
                if (c == "s")      nxt = KW_ELS;
                else if (c == "i") nxt = KW_ELI;
            end
            KW_ELS:   if (c == "e") nxt = KW_ELSE;
            KW_ELI:   if (c == "f") nxt = KW_ELIF;
            default:  nxt = KW_DEAD;
        endcase
        return nxt;
    endfunction

    // Token produced when an open word or number ends; invalid for other words.
    function automatic t_slot close_tok(input t_mode mode, input logic [3:0] kw,
                                        input logic [OUT_VALUE_W-1:0] val, input logic ovf);
        t_slot s;
        s = '0;
        if (mode == MODE_WORD) begin
            s.valid = 1'b1;
            unique case (kw)
                KW_RETURN: s.tok.kind = KIND_RETURN;
                KW_IF:     s.tok.kind = KIND_IF;
                KW_ELSE:   s.tok.kind = KIND_ELSE;
                KW_ELIF:   s.tok.kind = KIND_ELIF;
                default:   s.valid = 1'b0;
            endcase
        end else if (mode == MODE_NUM) begin
            s.valid     = 1'b1;
            s.tok.kind  = KIND_INT;
            s.tok.value = val;
            s.tok.ovf   = ovf;
        end
        return s;
    endfunction

endpackage

@@ rtl/keyword_integer_lexer.sv @@
// Top level of the keyword/integer lexer: input register, scan step, token queue.
//
// Usage: source bytes enter on the i_valid/o_ready channel, one byte per
// transaction, with i_end_of_source marking the final byte of a text. Tokens
// leave on the o_valid/i_ready channel, one token per transaction, with
// o_last_of_run set on the last token caused by a given byte.
// Path: a token reaches o_valid once the byte that causes it has passed the
// input register and the scan step on that register has written the token queue.
// Throughput: one byte per cycle while the queue has room. A byte that both
// ends a word or number and is punctuation (or ends the text) gives two tokens,
// which leave one at a time; the four-entry token queue decides the rate at the
// input, since a byte is scanned only when two queue entries are free.
// Reset: synchronous, active low; clears the scan state to idle with no open
// token and empties the queue. When the receiver stalls, tokens collect in
// the queue, then the input register holds its byte and o_ready drops; no
// byte or token is lost. Bytes that are neither letters, digits nor the
// five punctuation marks are skipped; words that are not keywords are dropped.
module keyword_integer_lexer
    import kil_pkg::*;
#(
    parameter int INT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_source_char,
    input  logic                   i_end_of_source,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [3:0]             o_token_kind,
    output logic [OUT_VALUE_W-1:0] o_int_value,
    output logic                   o_value_overflow,
    output logic                   o_last_of_run
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eos;

    // scan state
    t_mode                r_mode, n_mode;
    logic [3:0]           r_kw, n_kw;
    logic [INT_WIDTH-1:0] r_acc, n_acc;
    logic                 r_ovf, n_ovf;

    // token queue
    t_token           r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic consume, pop;
    logic is_letter, is_digit, is_alnum;
    logic [INT_WIDTH-1:0] base_acc, add_acc;
    logic                 base_ovf, add_sat;
    logic [INT_WIDTH+3:0] wide;
    t_slot tok1, tok2, push_a, push_b;

    assign consume = r_in_valid && (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_ready = !r_in_valid || consume;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_source_char;
            r_eos  <= i_end_of_source;
        end
    end

    assign is_letter = (r_char >= 8'd65 && r_char <= 8'd90) ||
                       (r_char >= 8'd97 && r_char <= 8'd122);
    assign is_digit  = r_char >= 8'd48 && r_char <= 8'd57;
    assign is_alnum  = is_letter || is_digit;

    // acc*10 + digit; saturate when it no longer fits in INT_WIDTH bits
    assign base_acc = (r_mode == MODE_NUM) ? r_acc : '0;
    assign base_ovf = (r_mode == MODE_NUM) && r_ovf;
    assign wide     = (INT_WIDTH+4)'({base_acc, 3'b000}) + (INT_WIDTH+4)'({base_acc, 1'b0})
                    + (INT_WIDTH+4)'(r_char[3:0]);
    assign add_sat  = base_ovf || (wide[INT_WIDTH+3:INT_WIDTH] != 4'd0);
    assign add_acc  = add_sat ? '1 : wide[INT_WIDTH-1:0];

    always_comb begin
        n_mode = r_mode;
        n_kw   = r_kw;
        n_acc  = r_acc;
        n_ovf  = r_ovf;
        tok1   = '0;
        tok2   = '0;

        if (r_mode == MODE_WORD) begin
            if (is_alnum) begin
                n_kw = kw_next(r_kw, r_char);
            end else begin
                tok1   = close_tok(r_mode, r_kw, OUT_VALUE_W'(r_acc), r_ovf);
                n_mode = MODE_IDLE;
                n_kw   = KW_START;
                n_acc  = '0;
                n_ovf  = 1'b0;
            end
        end else if (r_mode == MODE_NUM) begin
            if (is_digit) begin
                n_acc = add_acc;
                n_ovf = add_sat;
            end else begin
                tok1   = close_tok(r_mode, r_kw, OUT_VALUE_W'(r_acc), r_ovf);
                n_mode = MODE_IDLE;
                n_kw   = KW_START;
                n_acc  = '0;
                n_ovf  = 1'b0;
            end
        end

        if (n_mode == MODE_IDLE) begin
            if (is_letter) begin
                n_mode = MODE_WORD;
                n_kw   = kw_next(KW_START, r_char);
            end else if (is_digit) begin
                n_mode = MODE_NUM;
                n_acc  = add_acc;
                n_ovf  = add_sat;
            end else if (r_char == ";") begin
                tok2.valid = 1'b1; tok2.tok.kind = KIND_SEMI;
            end else if (r_char == ",") begin
                tok2.valid = 1'b1; tok2.tok.kind = KIND_COMMA;
            end else if (r_char == ".") begin
                tok2.valid = 1'b1; tok2.tok.kind = KIND_DOT;
            end else if (r_char == "(") begin
                tok2.valid = 1'b1; tok2.tok.kind = KIND_LPAREN;
            end else if (r_char == ")") begin
                tok2.valid = 1'b1; tok2.tok.kind = KIND_RPAREN;
            end
        end

        // end of text flushes the open token; punctuation leaves nothing open
        if (r_eos) begin
            if (!tok2.valid) begin
                tok2 = close_tok(n_mode, n_kw, OUT_VALUE_W'(n_acc), n_ovf);
            end
            n_mode = MODE_IDLE;
            n_kw   = KW_START;
            n_acc  = '0;
            n_ovf  = 1'b0;
        end

        tok1.tok.last = !tok2.valid;
        tok2.tok.last = 1'b1;
    end

    // pack the step's tokens in order into up to two queue writes
    always_comb begin
        if (tok1.valid) begin
            push_a = tok1;
            push_b = tok2;
        end else begin
            push_a = tok2;
            push_b = '0;
        end
        push_a.valid = push_a.valid && consume;
        push_b.valid = push_b.valid && consume;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_kw   <= KW_START;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else if (consume) begin
            r_mode <= n_mode;
            r_kw   <= n_kw;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_a.valid) begin
            r_fifo[r_wr_ptr] <= push_a.tok;
        end
        if (push_b.valid) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= push_b.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_a.valid) + PTR_W'(push_b.valid);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(push_a.valid) + CNT_W'(push_b.valid) - CNT_W'(pop);
        end
    end

    assign o_valid          = r_count != '0;
    assign o_token_kind     = r_fifo[r_rd_ptr].kind;
    assign o_int_value      = r_fifo[r_rd_ptr].value;
    assign o_value_overflow = r_fifo[r_rd_ptr].ovf;
    assign o_last_of_run    = r_fifo[r_rd_ptr].last;

    // ---- assertions ----
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("token queue overfilled");

    a_eos_resets_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_eos |=> r_mode == MODE_IDLE && r_kw == KW_START && !r_ovf)
        else $error("scan state not cleared after end of text");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_kind <= KIND_RPAREN)
        else $error("token kind out of range");

    a_value_only_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind != KIND_INT |-> o_int_value == '0 && !o_value_overflow)
        else $error("non-integer token carries a value");

    a_push_b_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_b.valid |-> push_a.valid && !push_a.tok.last)
        else $error("second token pushed without an earlier first token");

endmodule
